// File: hw/rtl/stx_etx_bcc_frame_parser_defines.svh
// ---------------------------------------------------------------------------
// stx_etx_bcc_frame_parser_defines
// assertion macros shared by the frame parser rtl
// ---------------------------------------------------------------------------
`ifndef STX_ETX_BCC_FRAME_PARSER_DEFINES_SVH
`define STX_ETX_BCC_FRAME_PARSER_DEFINES_SVH

// concurrent check, masked while reset is high
`define SEBFP_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("frame parser assertion failed");

// concurrent check that also holds across reset
`define SEBFP_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) (prop)) \
    else $error("frame parser assertion failed");

`endif

// File: hw/rtl/sebfp_pkg.sv
// ---------------------------------------------------------------------------
// sebfp_pkg
// types and constants of the stx/etx frame parser with xor block check
// ---------------------------------------------------------------------------
`default_nettype none

package sebfp_pkg;

  // framing bytes
  localparam logic [7:0] FRAME_HEAD = 8'h02;
  localparam logic [7:0] FRAME_TAIL = 8'h03;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_MAX = 1'b1;

  // parser phase
  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_LENGTH = 3'd1,
    PH_ID     = 3'd2,
    PH_DATA   = 3'd3,
    PH_TAIL   = 3'd4
  } phase_t;

  // per-word status code
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_DATA      = 3'd1,
    ST_OK        = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_BAD_CHECK = 3'd4,
    ST_BAD_TAIL  = 3'd5,
    ST_HEAD      = 3'd6
  } status_t;

  // one result word
  typedef struct packed {
    status_t    status;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/sebfp_in_stage.sv
// ---------------------------------------------------------------------------
// sebfp_in_stage
// input register holding one received byte until the parser takes it
// ---------------------------------------------------------------------------
`default_nettype none

module sebfp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       take,
  output logic            hold_valid,
  output logic [7:0]      hold_byte
);

  // free slot, or the held word leaves this cycle
  assign in_ready = !hold_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sebfp_core.sv
// ---------------------------------------------------------------------------
// sebfp_core
// frame state, id range registers and per-byte result logic
// ---------------------------------------------------------------------------
`default_nettype none

module sebfp_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sebfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            step,
  input  wire logic [7:0]                      rx_byte,
  output sebfp_pkg::result_t                   res
);
  import sebfp_pkg::*;

  logic [7:0] valid_id_min;
  logic [7:0] valid_id_max;
  phase_t     phase, phase_next;
  logic [7:0] check_acc, check_acc_next;
  logic [7:0] length_reg, length_reg_next;
  logic [7:0] position, position_next;
  logic [7:0] id_reg, id_reg_next;
  status_t    status;
  logic [7:0] dbyte;
  logic [7:0] dindex;
  logic       id_ok;
  logic       in_data;

  // id range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_id_min <= 8'h00;
      valid_id_max <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID_MIN: valid_id_min <= cfg_data;
        CFG_ID_MAX: valid_id_max <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign id_ok   = (rx_byte >= valid_id_min) && (rx_byte <= valid_id_max);
  // data field runs while position + 2 < total length
  assign in_data = ({1'b0, position} + 9'd2) < {1'b0, length_reg};

  // next state and result
  always_comb begin
    phase_next      = phase;
    check_acc_next  = check_acc;
    length_reg_next = length_reg;
    position_next   = position;
    id_reg_next     = id_reg;
    status          = ST_IDLE;
    dbyte           = 8'h00;
    dindex          = 8'h00;
    unique case (phase)
      PH_LENGTH: begin
        length_reg_next = rx_byte;
        check_acc_next  = check_acc ^ rx_byte;
        position_next   = 8'd2;
        phase_next      = PH_ID;
      end
      PH_ID: begin
        if (id_ok) begin
          id_reg_next    = rx_byte;
          check_acc_next = check_acc ^ rx_byte;
          position_next  = 8'd3;
          phase_next     = PH_DATA;
        end else begin
          status     = ST_BAD_ID;
          phase_next = PH_HEAD;
        end
      end
      PH_DATA: begin
        priority if (in_data) begin
          check_acc_next = check_acc ^ rx_byte;
          status         = ST_DATA;
          dbyte          = rx_byte;
          dindex         = position - 8'd3;
          position_next  = position + 8'd1;
        end else if (rx_byte == check_acc) begin
          position_next = position + 8'd1;
          phase_next    = PH_TAIL;
        end else begin
          status     = ST_BAD_CHECK;
          phase_next = PH_HEAD;
        end
      end
      PH_TAIL: begin
        status     = (rx_byte == FRAME_TAIL) ? ST_OK : ST_BAD_TAIL;
        phase_next = PH_HEAD;
      end
      default: begin
        phase_next = PH_HEAD;
        if (rx_byte == FRAME_HEAD) begin
          check_acc_next  = 8'h00;
          length_reg_next = 8'h00;
          position_next   = 8'd1;
          status          = ST_HEAD;
          phase_next      = PH_LENGTH;
        end
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD;
      check_acc  <= 8'h00;
      length_reg <= 8'h00;
      position   <= 8'h00;
      id_reg     <= 8'h00;
    end else if (step) begin
      phase      <= phase_next;
      check_acc  <= check_acc_next;
      length_reg <= length_reg_next;
      position   <= position_next;
      id_reg     <= id_reg_next;
    end
  end

  assign res.status       = status;
  assign res.data_byte    = dbyte;
  assign res.data_index   = dindex;
  assign res.frame_id     = id_reg_next;
  assign res.frame_length = length_reg_next;

endmodule

`default_nettype wire

// File: hw/rtl/sebfp_out_stage.sv
// ---------------------------------------------------------------------------
// sebfp_out_stage
// result register toward the downstream side
// ---------------------------------------------------------------------------
`default_nettype none

module sebfp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  sebfp_pkg::result_t      res_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sebfp_pkg::result_t      res_out
);
  import sebfp_pkg::*;

  // valid flag: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/stx_etx_bcc_frame_parser.sv
// ---------------------------------------------------------------------------
// stx_etx_bcc_frame_parser
// parses stx / length / id / data / xor check / etx frames, one byte a word
// ---------------------------------------------------------------------------
// channel   dir  signals                     contents
// s_axis    in   s_tvalid s_tready s_tdata   received byte
// m_axis    out  m_tvalid m_tready m_tdata   status word per byte
//                m_tuser
// cfg       in   cfg_we cfg_index cfg_data   id range registers
//
// one word per cycle sustained while m_tready does not stall; each accepted input
// word passes the input register, then the state update into the result register.
// the state update of phase, check and position sets the rate.
// rst is synchronous, active high; clears state and id range to 0..255.
// a stalled m_tready holds the result and, once the input register is full,
// drops s_tready.
// ---------------------------------------------------------------------------
`default_nettype none
`include "stx_etx_bcc_frame_parser_defines.svh"

module stx_etx_bcc_frame_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [31:0]                          m_tdata,   // [7:0] data_byte,
                                                          // [15:8] data_index,
                                                          // [23:16] frame_id,
                                                          // [31:24] frame_length
  output logic [2:0]                           m_tuser,   // [2:0] status
  input  wire logic                            cfg_we,
  input  wire logic [sebfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data
);
  import sebfp_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;
  result_t    res_core;
  result_t    res_out;

  // byte moves into the result register when that slot is free or emptying
  assign advance = hold_valid && (!m_tvalid || m_tready);

  sebfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .take       (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  sebfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .rx_byte   (hold_byte),
    .res       (res_core)
  );

  sebfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (res_core),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_out   (res_out)
  );

  // output packing
  assign m_tuser = res_out.status;
  assign m_tdata = {res_out.frame_length, res_out.frame_id,
                    res_out.data_index, res_out.data_byte};

  // checks
  `SEBFP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!m_tvalid && !hold_valid))
  `SEBFP_ASSERT(a_payload_only_data, clk, rst,
    (m_tvalid && (m_tuser != ST_DATA)) |-> (m_tdata[15:0] == 16'h0000))
  `SEBFP_ASSERT(a_head_clears_length, clk, rst,
    (m_tvalid && (m_tuser == ST_HEAD)) |-> (m_tdata[31:24] == 8'h00))
  `SEBFP_ASSERT(a_hold_kept, clk, rst, (hold_valid && !advance) |=> hold_valid)

endmodule

`default_nettype wire
